[sv/c2d_pkg.sv]
// Shared types, constants and codes for the 2D convolution output element block.
package c2d_pkg;

   localparam int INPUT_WORDS    = 4096;
   localparam int WEIGHT_WORDS   = 4096;
   localparam int MAX_CHANNELS   = 64;
   localparam int DATA_BITS      = 16;
   localparam int FRAC_BITS      = 8;
   localparam int IN_ADDR_BITS   = $clog2(INPUT_WORDS);
   localparam int WT_ADDR_BITS   = $clog2(WEIGHT_WORDS);
   localparam int BIAS_ADDR_BITS = $clog2(MAX_CHANNELS);
   localparam int PROD_BITS      = 2 * DATA_BITS;
   localparam int ACC_BITS       = 48;
   localparam int SUM_BITS       = 32;
   localparam int IA_BITS        = 24;
   localparam int WA_BITS        = 19;
   localparam int CSR_DATA_BITS  = 7;

   typedef enum logic [1:0] {
      ACT_INPUT   = 2'd0,
      ACT_WEIGHT  = 2'd1,
      ACT_BIAS    = 2'd2,
      ACT_COMPUTE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_IN_CHANNELS  = 3'd0,
      REG_IN_HEIGHT    = 3'd1,
      REG_IN_WIDTH     = 3'd2,
      REG_OUT_CHANNELS = 3'd3,
      REG_KERNEL_SIZE  = 3'd4,
      REG_STRIDE_STEP  = 3'd5,
      REG_PAD_AMOUNT   = 3'd6,
      REG_BIAS_ENABLE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      action_type         action;
      logic [11:0]        address;
      logic signed [15:0] value;
      logic [5:0]         out_channel;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sum;
      logic               overflow;
      logic               bad_coordinate;
   } rsp_type;

   typedef struct packed {
      logic [6:0] in_channels;
      logic [6:0] in_height;
      logic [6:0] in_width;
      logic [6:0] out_channels;
      logic [2:0] kernel_size;
      logic [2:0] stride_step;
      logic [1:0] pad_amount;
      logic       bias_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      in_channels:  7'd1,
      in_height:    7'd1,
      in_width:     7'd1,
      out_channels: 7'd1,
      kernel_size:  3'd1,
      stride_step:  3'd1,
      pad_amount:   2'd0,
      bias_enable:  1'b1
   };

   typedef struct packed {
      logic setup1;
      logic setup2;
      logic setup3;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bad;
      logic no_taps;
      logic last_tap;
   } dp_status_type;

endpackage

[sv/c2d_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/c2d_ctrl.sv]
// Sequencer: setup, tap loop, pipeline drain and result strobe for one compute request.
module c2d_ctrl import c2d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP1 = 8'b0000_0010,
      ST_SETUP2 = 8'b0000_0100,
      ST_SETUP3 = 8'b0000_1000,
      ST_RUN    = 8'b0001_0000,
      ST_DRAIN1 = 8'b0010_0000,
      ST_DRAIN2 = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_SETUP1;
            end
         end
         ST_SETUP1: state_in = ST_SETUP2;
         ST_SETUP2: state_in = ST_SETUP3;
         ST_SETUP3: begin
            if (status.bad || status.no_taps) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.last_tap) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.setup1 = (state_ff == ST_SETUP1);
   assign cmd.setup2 = (state_ff == ST_SETUP2);
   assign cmd.setup3 = (state_ff == ST_SETUP3);
   assign cmd.issue  = (state_ff == ST_RUN);
   assign cmd.finish = (state_ff == ST_FINISH);
   assign busy       = (state_ff != ST_IDLE);

endmodule

[sv/c2d_datapath.sv]
// Stores, address walk, multiply-accumulate pipeline and saturation.
module c2d_datapath import c2d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          accept,
   input  req_type       req,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output rsp_type       rsp,
   output logic          rsp_valid
);

   logic [5:0]                 oc_ff, oc_in, orow_ff, orow_in, ocol_ff, ocol_in;
   logic [8:0]                 rpos_ff, rpos_in, cpos_ff, cpos_in;
   logic [13:0]                hw_ff, hw_in;
   logic [9:0]                 km1w_ff, km1w_in;
   logic [12:0]                ocin_ff, ocin_in;
   logic [15:0]                ocink_ff, ocink_in;
   logic signed [9:0]          ih0_ff, ih0_in, iw0_ff, iw0_in;
   logic signed [9:0]          ih_ff, ih_in, iw_ff, iw_in;
   logic signed [IA_BITS-1:0]  ia_ff, ia_in, chan_step_ff, chan_step_in;
   logic [WA_BITS-1:0]         wa_ff, wa_in;
   logic [6:0]                 ic_ff, ic_in;
   logic [2:0]                 kh_ff, kh_in, kw_ff, kw_in;
   logic                       bad_ff, bad_in;
   logic                       v1_ff, v1_in, v2_ff, v2_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [2:0]                 s_eff, km1;
   logic [7:0]                 span_h, span_w;
   logic signed [9:0]          ih0_calc, iw0_calc;
   logic signed [IA_BITS-1:0]  row_step;
   logic                       tap_ok, last_kw, last_kh, last_ic;
   logic [DATA_BITS-1:0]       in_rd, wt_rd, bias_rd;
   logic [ACC_BITS-SUM_BITS:0] acc_hi;
   logic                       sat;

   c2d_ram #(.WIDTH(DATA_BITS), .DEPTH(INPUT_WORDS)) u_input_store (
      .clock   (clock),
      .wr_en   (accept && (req.action == ACT_INPUT)),
      .wr_addr (req.address[IN_ADDR_BITS-1:0]),
      .wr_data (req.value[DATA_BITS-1:0]),
      .rd_addr (ia_ff[IN_ADDR_BITS-1:0]),
      .rd_data (in_rd)
   );

   c2d_ram #(.WIDTH(DATA_BITS), .DEPTH(WEIGHT_WORDS)) u_weight_store (
      .clock   (clock),
      .wr_en   (accept && (req.action == ACT_WEIGHT)),
      .wr_addr (req.address[WT_ADDR_BITS-1:0]),
      .wr_data (req.value[DATA_BITS-1:0]),
      .rd_addr (wa_ff[WT_ADDR_BITS-1:0]),
      .rd_data (wt_rd)
   );

   c2d_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_CHANNELS)) u_bias_store (
      .clock   (clock),
      .wr_en   (accept && (req.action == ACT_BIAS)),
      .wr_addr (req.address[BIAS_ADDR_BITS-1:0]),
      .wr_data (req.value[DATA_BITS-1:0]),
      .rd_addr (oc_ff[BIAS_ADDR_BITS-1:0]),
      .rd_data (bias_rd)
   );

   assign s_eff    = (cfg.stride_step == 3'd0) ? 3'd1 : cfg.stride_step;
   assign km1      = cfg.kernel_size - 3'd1;
   assign span_h   = 8'(cfg.in_height) + {5'd0, cfg.pad_amount, 1'b0};
   assign span_w   = 8'(cfg.in_width) + {5'd0, cfg.pad_amount, 1'b0};
   assign ih0_calc = signed'(10'(rpos_ff)) - signed'(10'(cfg.pad_amount));
   assign iw0_calc = signed'(10'(cpos_ff)) - signed'(10'(cfg.pad_amount));
   assign row_step = signed'(IA_BITS'(cfg.in_width)) - signed'(IA_BITS'(km1));

   assign last_kw = (kw_ff == km1);
   assign last_kh = (kh_ff == km1);
   assign last_ic = (ic_ff == (cfg.in_channels - 7'd1));

   // padding taps and taps beyond either store add nothing
   assign tap_ok = (ih_ff >= 10'sd0) && (ih_ff < signed'(10'(cfg.in_height)))
                && (iw_ff >= 10'sd0) && (iw_ff < signed'(10'(cfg.in_width)))
                && (ia_ff[IA_BITS-1:IN_ADDR_BITS] == '0)
                && (wa_ff[WA_BITS-1:WT_ADDR_BITS] == '0);

   assign acc_hi = acc_ff[ACC_BITS-1:SUM_BITS-1];
   assign sat    = !((&acc_hi) || !(|acc_hi));

   always_comb begin
      oc_in        = oc_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      rpos_in      = rpos_ff;
      cpos_in      = cpos_ff;
      hw_in        = hw_ff;
      km1w_in      = km1w_ff;
      ocin_in      = ocin_ff;
      ocink_in     = ocink_ff;
      ih0_in       = ih0_ff;
      iw0_in       = iw0_ff;
      ih_in        = ih_ff;
      iw_in        = iw_ff;
      ia_in        = ia_ff;
      chan_step_in = chan_step_ff;
      wa_in        = wa_ff;
      ic_in        = ic_ff;
      kh_in        = kh_ff;
      kw_in        = kw_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;

      if (accept) begin
         oc_in   = req.out_channel;
         orow_in = req.out_row;
         ocol_in = req.out_col;
      end

      if (cmd.setup1) begin
         rpos_in = 9'(orow_ff) * 9'(s_eff);
         cpos_in = 9'(ocol_ff) * 9'(s_eff);
         hw_in   = 14'(cfg.in_height) * 14'(cfg.in_width);
         km1w_in = 10'(km1) * 10'(cfg.in_width);
         ocin_in = 13'(oc_ff) * 13'(cfg.in_channels);
      end

      if (cmd.setup2) begin
         // row valid iff row*stride + k <= in + 2*pad, same for columns
         bad_in = ({1'b0, oc_ff} >= cfg.out_channels)
               || ((10'(rpos_ff) + 10'(cfg.kernel_size)) > 10'(span_h))
               || ((10'(cpos_ff) + 10'(cfg.kernel_size)) > 10'(span_w));
         ih0_in = ih0_calc;
         iw0_in = iw0_calc;
         ih_in  = ih0_calc;
         iw_in  = iw0_calc;
         ia_in  = IA_BITS'(ih0_calc) * signed'(IA_BITS'(cfg.in_width))
                + IA_BITS'(iw0_calc);
         chan_step_in = signed'(IA_BITS'(hw_ff)) - signed'(IA_BITS'(km1w_ff))
                      - signed'(IA_BITS'(km1));
         ocink_in = 16'(ocin_ff) * 16'(cfg.kernel_size);
      end

      if (cmd.setup3) begin
         wa_in = WA_BITS'(ocink_ff) * WA_BITS'(cfg.kernel_size);
         ic_in = '0;
         kh_in = '0;
         kw_in = '0;
         if (cfg.bias_enable) begin
            acc_in = {{(ACC_BITS-DATA_BITS-FRAC_BITS){bias_rd[DATA_BITS-1]}},
                      bias_rd, FRAC_BITS'(0)};
         end else begin
            acc_in = '0;
         end
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end

      if (cmd.issue) begin
         wa_in = wa_ff + WA_BITS'(1);
         if (last_kw) begin
            kw_in = '0;
            iw_in = iw0_ff;
            if (last_kh) begin
               kh_in = '0;
               ih_in = ih0_ff;
               ic_in = ic_ff + 7'd1;
               ia_in = ia_ff + chan_step_ff;
            end else begin
               kh_in = kh_ff + 3'd1;
               ih_in = ih_ff + 10'sd1;
               ia_in = ia_ff + row_step;
            end
         end else begin
            kw_in = kw_ff + 3'd1;
            iw_in = iw_ff + 10'sd1;
            ia_in = ia_ff + IA_BITS'(1);
         end
      end

      if (cmd.finish) begin
         if (bad_ff) begin
            rsp_in.sum            = '0;
            rsp_in.overflow       = 1'b0;
            rsp_in.bad_coordinate = 1'b1;
         end else begin
            if (sat) begin
               rsp_in.sum = acc_ff[ACC_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                               : {1'b0, {(SUM_BITS-1){1'b1}}};
            end else begin
               rsp_in.sum = acc_ff[SUM_BITS-1:0];
            end
            rsp_in.overflow       = sat;
            rsp_in.bad_coordinate = 1'b0;
         end
      end
   end

   assign v1_in        = cmd.issue && tap_ok;
   assign v2_in        = v1_ff;
   assign prod_in      = $signed(in_rd) * $signed(wt_rd);
   assign rsp_valid_in = cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oc_ff        <= oc_in;
      orow_ff      <= orow_in;
      ocol_ff      <= ocol_in;
      rpos_ff      <= rpos_in;
      cpos_ff      <= cpos_in;
      hw_ff        <= hw_in;
      km1w_ff      <= km1w_in;
      ocin_ff      <= ocin_in;
      ocink_ff     <= ocink_in;
      ih0_ff       <= ih0_in;
      iw0_ff       <= iw0_in;
      ih_ff        <= ih_in;
      iw_ff        <= iw_in;
      ia_ff        <= ia_in;
      chan_step_ff <= chan_step_in;
      wa_ff        <= wa_in;
      ic_ff        <= ic_in;
      kh_ff        <= kh_in;
      kw_ff        <= kw_in;
      bad_ff       <= bad_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_ff       <= rsp_in;
   end

   assign status.bad      = bad_ff;
   assign status.no_taps  = (cfg.kernel_size == 3'd0) || (cfg.in_channels == 7'd0);
   assign status.last_tap = last_kw && last_kh && last_ic;
   assign rsp             = rsp_ff;
   assign rsp_valid       = rsp_valid_ff;

endmodule

[sv/conv2d_output_element_top.sv]
// Top level of the 2D convolution output element: register file, sequencer and datapath.
//
// Load requests (input, weight or bias word) never raise busy.
// A compute request raises busy and returns one result, shown for exactly one
// cycle with rsp_valid; it cannot be held off. A compute runs setup, then one kernel
// tap per cycle through a single multiply-accumulate unit fed by one read port of
// each store, then pipeline drain and the result; an out-of-range coordinate, zero
// channels or zero kernel size skip the tap loop and the drain.
// A new request may be accepted in the cycle rsp_valid is high.
module conv2d_output_element_top import c2d_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   output rsp_type                  rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   cfg_type       cfg_ff, cfg_in;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          accept;

   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_IN_CHANNELS:  cfg_in.in_channels  = csr_data[6:0];
            REG_IN_HEIGHT:    cfg_in.in_height    = csr_data[6:0];
            REG_IN_WIDTH:     cfg_in.in_width     = csr_data[6:0];
            REG_OUT_CHANNELS: cfg_in.out_channels = csr_data[6:0];
            REG_KERNEL_SIZE:  cfg_in.kernel_size  = csr_data[2:0];
            REG_STRIDE_STEP:  cfg_in.stride_step  = csr_data[2:0];
            REG_PAD_AMOUNT:   cfg_in.pad_amount   = csr_data[1:0];
            REG_BIAS_ENABLE:  cfg_in.bias_enable  = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c2d_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .go     (accept && (req_payload.action == ACT_COMPUTE)),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   c2d_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .req       (req_payload),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_payload),
      .rsp_valid (rsp_valid)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.bad_coordinate) |->
         (rsp_payload.sum == '0) && !rsp_payload.overflow)
      else $error("bad coordinate result carries a value");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.overflow) |->
         ((rsp_payload.sum == 32'sh7FFF_FFFF) || (rsp_payload.sum == 32'sh8000_0000)))
      else $error("overflow flagged without a saturated sum");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && (req_payload.action == ACT_COMPUTE)))
      else $error("busy raised without a compute request");

endmodule
